// ----- sv/stpd_pkg.sv -----
// Shared constants and types for the smoothed threshold peak detector.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package stpd_pkg;

    localparam int DEFAULT_SAMPLE_WIDTH = 16;
    localparam int DEFAULT_MAX_SAMPLES  = 131072;
    localparam int POSITION_WIDTH       = 17;
    localparam int RESULT_DEPTH         = 3;
    localparam int COUNT_WIDTH          = 2;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOW_THRESHOLD  = 2'd1;

    // reset levels in Q7.8
    localparam int HIGH_THRESHOLD_RESET = 2511;
    localparam int LOW_THRESHOLD_RESET  = 1280;

    // result kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [POSITION_WIDTH-1:0] position;
        logic                      exceeded;
        logic                      end_of_run;
    } stpd_res_ctrl_t;

endpackage

// ----- sv/stpd_if.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on stpd_pkg for widths.
`timescale 1ns / 1ps

interface stpd_in_if #(
    parameter int SAMPLE_WIDTH = stpd_pkg::DEFAULT_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface stpd_out_if #(
    parameter int SAMPLE_WIDTH = stpd_pkg::DEFAULT_SAMPLE_WIDTH
);
    logic                                     valid;
    logic                                     ready;
    logic                                     kind;
    logic signed [SAMPLE_WIDTH-1:0]           value;
    logic [stpd_pkg::POSITION_WIDTH-1:0]      position;
    logic                                     exceeded;
    logic                                     end_of_run;

    modport source (output valid, output kind, output value, output position,
                    output exceeded, output end_of_run, input ready);
    modport sink   (input valid, input kind, input value, input position,
                    input exceeded, input end_of_run, output ready);
endinterface

// ----- sv/stpd_step.sv -----
// Per-sample datapath: smoothing, threshold detector, peak tracking and the
// next stream state. Purely combinational; depends on stpd_pkg.
`timescale 1ns / 1ps

module stpd_step #(
    parameter int SAMPLE_WIDTH = stpd_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int MAX_SAMPLES  = stpd_pkg::DEFAULT_MAX_SAMPLES,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    input  logic                                 is_last,
    input  logic signed [SAMPLE_WIDTH-1:0]       older,
    input  logic signed [SAMPLE_WIDTH-1:0]       newer,
    input  logic [CW-1:0]                        seen,
    input  logic                                 armed,
    input  logic signed [SAMPLE_WIDTH-1:0]       peak_value,
    input  logic [stpd_pkg::POSITION_WIDTH-1:0]  peak_position,
    input  logic signed [SAMPLE_WIDTH-1:0]       high_threshold,
    input  logic signed [SAMPLE_WIDTH-1:0]       low_threshold,
    output logic [stpd_pkg::COUNT_WIDTH-1:0]     res_count,
    output logic signed [SAMPLE_WIDTH-1:0]       res_value [stpd_pkg::RESULT_DEPTH],
    output stpd_pkg::stpd_res_ctrl_t             res_ctrl  [stpd_pkg::RESULT_DEPTH],
    output logic signed [SAMPLE_WIDTH-1:0]       older_next,
    output logic signed [SAMPLE_WIDTH-1:0]       newer_next,
    output logic [CW-1:0]                        seen_next,
    output logic                                 armed_next,
    output logic signed [SAMPLE_WIDTH-1:0]       peak_value_next,
    output logic [stpd_pkg::POSITION_WIDTH-1:0]  peak_position_next
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int EW  = SAMPLE_WIDTH + 2;
    localparam int PW  = stpd_pkg::POSITION_WIDTH;
    localparam logic [CW-1:0] LAST_INDEX = CW'(MAX_SAMPLES - 1);
    localparam logic [CW-1:0] SEEN_MAX   = CW'(MAX_SAMPLES);

    // saturate an index at the bound, then keep the low position bits
    function automatic logic [PW-1:0] pos_of(input logic [CW-1:0] idx);
        logic [CW-1:0] cl;
        logic [31:0]   wide;
        cl   = (idx > LAST_INDEX) ? LAST_INDEX : idx;
        wide = 32'(cl);
        return wide[PW-1:0];
    endfunction

    logic signed [EW-1:0] x_e, older_e, newer_e;
    logic signed [EW-1:0] sum_first, sum_mid, sum_last;
    logic signed [EW-1:0] q_first, q_mid, q_last;

    logic                 start;
    logic [CW-1:0]        idx1;
    logic signed [SW-1:0] v1, v2, p1v, p2v;
    logic [PW-1:0]        pos1, pos2, p1p, p2p;
    logic                 exc1, exc2, arm1, arm2;

    stpd_pkg::stpd_res_ctrl_t summary_ctrl;

    always_comb
    begin
        x_e     = EW'(sample);
        older_e = EW'(older);
        newer_e = EW'(newer);

        sum_first = (newer_e <<< 1) + newer_e + x_e;
        sum_mid   = older_e + (newer_e <<< 1) + x_e;
        sum_last  = newer_e + (x_e <<< 1) + x_e;
        q_first   = sum_first >>> 2;
        q_mid     = sum_mid >>> 2;
        q_last    = sum_last >>> 2;

        start = (seen == '0);

        // first emitted sample of this transaction
        if (start)
        begin
            v1   = sample;
            idx1 = '0;
        end
        else
        begin
            v1   = (seen == CW'(1)) ? SW'(q_first) : SW'(q_mid);
            idx1 = seen - CW'(1);
        end
        pos1 = pos_of(idx1);

        if ((idx1 == '0) || (v1 > peak_value))
        begin
            p1v = v1;
            p1p = pos1;
        end
        else
        begin
            p1v = peak_value;
            p1p = peak_position;
        end
        exc1 = armed && (v1 > high_threshold);
        arm1 = (armed && !exc1) || (v1 < low_threshold);

        // closing sample of a stream, never the first index
        v2   = SW'(q_last);
        pos2 = pos_of(seen);
        if (v2 > p1v)
        begin
            p2v = v2;
            p2p = pos2;
        end
        else
        begin
            p2v = p1v;
            p2p = p1p;
        end
        exc2 = arm1 && (v2 > high_threshold);
        arm2 = (arm1 && !exc2) || (v2 < low_threshold);

        summary_ctrl.kind       = stpd_pkg::KIND_SUMMARY;
        summary_ctrl.position   = start ? p1p : p2p;
        summary_ctrl.exceeded   = 1'b0;
        summary_ctrl.end_of_run = 1'b1;

        res_value[0]           = v1;
        res_ctrl[0].kind       = stpd_pkg::KIND_SAMPLE;
        res_ctrl[0].position   = pos1;
        res_ctrl[0].exceeded   = exc1;
        res_ctrl[0].end_of_run = 1'b0;

        if (start)
        begin
            res_value[1] = p1v;
            res_ctrl[1]  = summary_ctrl;
        end
        else
        begin
            res_value[1]           = v2;
            res_ctrl[1].kind       = stpd_pkg::KIND_SAMPLE;
            res_ctrl[1].position   = pos2;
            res_ctrl[1].exceeded   = exc2;
            res_ctrl[1].end_of_run = 1'b0;
        end
        res_value[2] = p2v;
        res_ctrl[2]  = summary_ctrl;

        if (is_last)
        begin
            // stream closes: back to reset state
            res_count          = start ? 2'd2 : 2'd3;
            older_next         = '0;
            newer_next         = '0;
            seen_next          = '0;
            armed_next         = 1'b1;
            peak_value_next    = '0;
            peak_position_next = '0;
        end
        else if (start)
        begin
            res_count          = 2'd0;
            older_next         = older;
            newer_next         = sample;
            seen_next          = CW'(1);
            armed_next         = armed;
            peak_value_next    = peak_value;
            peak_position_next = peak_position;
        end
        else
        begin
            res_count          = 2'd1;
            older_next         = newer;
            newer_next         = sample;
            seen_next          = (seen < SEEN_MAX) ? seen + CW'(1) : seen;
            armed_next         = arm1;
            peak_value_next    = p1v;
            peak_position_next = p1p;
        end
    end

endmodule

// ----- sv/smooth_threshold_peak_detector_core.sv -----
// Top level of the smoothed threshold peak detector: configuration and stream
// state registers, result queue and checks. Depends on stpd_pkg, stpd_if.sv
// and stpd_step.
`timescale 1ns / 1ps

// Usage:
//   samples : valid/ready sink of signed Q7.8 samples; is_last closes a stream.
//   results : valid/ready source of result transactions. Each sample after the
//             first of a stream yields the smoothed previous sample; the last
//             sample also yields the smoothed last sample and a peak summary
//             (kind = summary, end_of_run = 1). A one-sample stream yields the
//             sample itself and the summary.
//   cfg_we/cfg_index/cfg_data : register writes, index 0 high threshold,
//             index 1 low threshold, other indexes ignored. Write only while
//             idle.
//   Output: results of an accepted sample are valid on the next cycle.
//   Throughput: one sample per cycle while results drain; after a closing
//             sample the input stalls while its 2 or 3 results leave the
//             three-entry result queue one per cycle.
//   Reset: thresholds return to 2511 and 1280, stream state clears, queue empty.
//   Stall: when results.ready is low the queue holds and samples.ready drops
//             once a result is waiting and cannot leave.
module smooth_threshold_peak_detector_core #(
    parameter int SAMPLE_WIDTH = stpd_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int MAX_SAMPLES  = stpd_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    stpd_in_if.sink                                samples,
    stpd_out_if.source                             results,
    input  logic                                   cfg_we,
    input  logic [stpd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]                cfg_data
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int PW    = stpd_pkg::POSITION_WIDTH;
    localparam int DEPTH = stpd_pkg::RESULT_DEPTH;
    localparam int NW    = stpd_pkg::COUNT_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] high_reg, low_reg;
    logic signed [SAMPLE_WIDTH-1:0] older_reg, newer_reg, peak_value_reg;
    logic [PW-1:0]                  peak_position_reg;
    logic [CW-1:0]                  seen_reg;
    logic                           armed_reg;

    logic signed [SAMPLE_WIDTH-1:0] older_next, newer_next, peak_value_next;
    logic [PW-1:0]                  peak_position_next;
    logic [CW-1:0]                  seen_next;
    logic                           armed_next;

    logic [NW-1:0]                  res_count;
    logic signed [SAMPLE_WIDTH-1:0] res_value [DEPTH];
    stpd_pkg::stpd_res_ctrl_t       res_ctrl  [DEPTH];

    logic signed [SAMPLE_WIDTH-1:0] q_value_reg [DEPTH];
    stpd_pkg::stpd_res_ctrl_t       q_ctrl_reg  [DEPTH];
    logic [NW-1:0]                  cnt_reg;

    logic in_fire, out_fire;

    stpd_step #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_step (
        .sample             (samples.sample),
        .is_last            (samples.is_last),
        .older              (older_reg),
        .newer              (newer_reg),
        .seen               (seen_reg),
        .armed              (armed_reg),
        .peak_value         (peak_value_reg),
        .peak_position      (peak_position_reg),
        .high_threshold     (high_reg),
        .low_threshold      (low_reg),
        .res_count          (res_count),
        .res_value          (res_value),
        .res_ctrl           (res_ctrl),
        .older_next         (older_next),
        .newer_next         (newer_next),
        .seen_next          (seen_next),
        .armed_next         (armed_next),
        .peak_value_next    (peak_value_next),
        .peak_position_next (peak_position_next)
    );

    // take a sample when the queue is empty or its only entry leaves now
    assign samples.ready = (cnt_reg == '0) || ((cnt_reg == NW'(1)) && results.ready);
    assign in_fire       = samples.valid && samples.ready;
    assign out_fire      = results.valid && results.ready;

    assign results.valid      = (cnt_reg != '0);
    assign results.value      = q_value_reg[0];
    assign results.kind       = q_ctrl_reg[0].kind;
    assign results.position   = q_ctrl_reg[0].position;
    assign results.exceeded   = q_ctrl_reg[0].exceeded;
    assign results.end_of_run = q_ctrl_reg[0].end_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg          <= SAMPLE_WIDTH'(stpd_pkg::HIGH_THRESHOLD_RESET);
            low_reg           <= SAMPLE_WIDTH'(stpd_pkg::LOW_THRESHOLD_RESET);
            older_reg         <= '0;
            newer_reg         <= '0;
            seen_reg          <= '0;
            armed_reg         <= 1'b1;
            peak_value_reg    <= '0;
            peak_position_reg <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    stpd_pkg::CFG_HIGH_THRESHOLD: high_reg <= cfg_data;
                    stpd_pkg::CFG_LOW_THRESHOLD:  low_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (in_fire)
            begin
                older_reg         <= older_next;
                newer_reg         <= newer_next;
                seen_reg          <= seen_next;
                armed_reg         <= armed_next;
                peak_value_reg    <= peak_value_next;
                peak_position_reg <= peak_position_next;
                cnt_reg           <= res_count;
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg - NW'(1);
            end
        end
    end

    // result queue payload: load on accept, shift toward the head on pop
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                q_value_reg[i] <= res_value[i];
                q_ctrl_reg[i]  <= res_ctrl[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                q_value_reg[i] <= q_value_reg[i+1];
                q_ctrl_reg[i]  <= q_ctrl_reg[i+1];
            end
        end
    end

    a_last_gives_results: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && samples.is_last |=> results.valid && cnt_reg >= NW'(2))
        else $error("closing sample did not load its results");

    a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.kind == stpd_pkg::KIND_SUMMARY)
            |-> results.end_of_run && !results.exceeded)
        else $error("summary result with wrong flags");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond bound");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && samples.is_last |=> seen_reg == '0 && armed_reg)
        else $error("stream state not cleared after closing sample");

endmodule

// ----- tb/stpd_smoothing_checker.sv -----
// Checker for the smoothed threshold peak detector: watches the sample, result and
// register-write ports, predicts every result and compares it field by field.
// Depends on stpd_pkg and the channel interfaces in stpd_if.sv.
`timescale 1ns / 1ps

module stpd_smoothing_checker #(
    parameter int SAMPLE_WIDTH = stpd_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int MAX_SAMPLES  = stpd_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    stpd_in_if                                   samples,
    stpd_out_if                                  results,
    input  logic                                 cfg_we,
    input  logic [stpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]              cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked,
    output int                                   reports
);

    localparam int PW = stpd_pkg::POSITION_WIDTH;

    typedef struct {
        logic                           kind;
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [PW-1:0]                  position;
        logic                           exceeded;
        logic                           end_of_run;
    } stpd_result_t;

    // register copies and stream state of the predictor
    logic signed [SAMPLE_WIDTH-1:0] high_level;
    logic signed [SAMPLE_WIDTH-1:0] low_level;
    logic signed [SAMPLE_WIDTH-1:0] sample_m2;
    logic signed [SAMPLE_WIDTH-1:0] sample_m1;
    logic signed [SAMPLE_WIDTH-1:0] peak_level;
    int                             stream_count;
    int                             peak_index;
    logic                           armed;

    stpd_result_t awaited_results[$];
    int           mismatches;
    int           matched;
    int           exceed_seen;

    task automatic clear_stream();
        sample_m2    = '0;
        sample_m1    = '0;
        stream_count = 0;
        armed        = 1'b1;
        peak_level   = '0;
        peak_index   = 0;
    endtask

    // floor division by 4 of a tap sum
    function automatic logic signed [SAMPLE_WIDTH-1:0] quarter(input int sum);
        int q;
        q = sum >>> 2;
        return q[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic emit_smoothed(input logic signed [SAMPLE_WIDTH-1:0] level,
                                 input int idx);
        stpd_result_t r;
        int           pos;
        pos = (idx > MAX_SAMPLES - 1) ? MAX_SAMPLES - 1 : idx;
        if (idx == 0 || level > peak_level)
        begin
            peak_level = level;
            peak_index = pos;
        end
        r.exceeded = 1'b0;
        if (level > high_level && armed)
        begin
            r.exceeded = 1'b1;
            armed      = 1'b0;
        end
        if (level < low_level)
            armed = 1'b1;
        r.kind       = stpd_pkg::KIND_SAMPLE;
        r.value      = level;
        r.position   = pos[PW-1:0];
        r.end_of_run = 1'b0;
        awaited_results.push_back(r);
    endtask

    task automatic smooth_and_track(input logic signed [SAMPLE_WIDTH-1:0] x,
                                    input logic last);
        stpd_result_t s;
        int           c;
        c = stream_count;
        if (c == 0)
        begin
            if (!last)
            begin
                sample_m1    = x;
                stream_count = 1;
                return;
            end
            emit_smoothed(x, 0);
        end
        else
        begin
            if (c == 1)
                emit_smoothed(quarter(3 * int'(sample_m1) + int'(x)), 0);
            else
                emit_smoothed(quarter(int'(sample_m2) + 2 * int'(sample_m1) + int'(x)), c - 1);
            if (!last)
            begin
                sample_m2 = sample_m1;
                sample_m1 = x;
                if (stream_count < MAX_SAMPLES)
                    stream_count++;
                return;
            end
            emit_smoothed(quarter(int'(sample_m1) + 3 * int'(x)), c);
        end
        s.kind       = stpd_pkg::KIND_SUMMARY;
        s.value      = peak_level;
        s.position   = peak_index[PW-1:0];
        s.exceeded   = 1'b0;
        s.end_of_run = 1'b1;
        awaited_results.push_back(s);
        clear_stream();
    endtask

    task automatic compare_field(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stpd_result_t want;
        if (!rst_n)
        begin
            high_level = SAMPLE_WIDTH'(stpd_pkg::HIGH_THRESHOLD_RESET);
            low_level  = SAMPLE_WIDTH'(stpd_pkg::LOW_THRESHOLD_RESET);
            clear_stream();
            awaited_results.delete();
            mismatches  = 0;
            matched     = 0;
            exceed_seen = 0;
        end
        else
        begin
            // results are registered after their sample is taken, so check before predicting
            if (results.valid && results.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result transaction: kind %0d value %0d position %0d",
                           results.kind, results.value, results.position);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("kind", want.kind, results.kind);
                    compare_field("value", want.value, results.value);
                    compare_field("position", want.position, results.position);
                    compare_field("exceeded", want.exceeded, results.exceeded);
                    compare_field("end_of_run", want.end_of_run, results.end_of_run);
                    matched++;
                    if (results.exceeded === 1'b1)
                        exceed_seen++;
                end
            end
            if (samples.valid && samples.ready)
                smooth_and_track(samples.sample, samples.is_last);
            if (cfg_we)
            begin
                case (cfg_index)
                    stpd_pkg::CFG_HIGH_THRESHOLD: high_level = cfg_data;
                    stpd_pkg::CFG_LOW_THRESHOLD:  low_level  = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count <= mismatches;
        pending    <= awaited_results.size();
        checked    <= matched;
        reports    <= exceed_seen;
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the smoothed threshold
// peak detector. Depends on stpd_pkg, stpd_if.sv and stpd_smoothing_checker.
`timescale 1ns / 1ps

module tb;

    localparam int SW           = stpd_pkg::DEFAULT_SAMPLE_WIDTH;
    localparam int IW           = stpd_pkg::CFG_INDEX_WIDTH;
    localparam int RANDOM_ITEMS = 260;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LEVEL_MAX    = 32767;
    localparam int LEVEL_MIN    = -32768;
    localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [IW-1:0] cfg_index;
    logic [SW-1:0] cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          reports;
    int unsigned cycle_count;

    int sent_count;
    int stream_total;
    int burst_left;
    int cur_high;
    int cur_low;
    bit aim_high;
    bit gaps_on;
    bit stalls_on;

    stpd_in_if  #(.SAMPLE_WIDTH(SW)) smp_if ();
    stpd_out_if #(.SAMPLE_WIDTH(SW)) res_if ();

    smooth_threshold_peak_detector_core #(
        .SAMPLE_WIDTH (SW),
        .MAX_SAMPLES  (stpd_pkg::DEFAULT_MAX_SAMPLES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (smp_if.sink),
        .results   (res_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stpd_smoothing_checker #(
        .SAMPLE_WIDTH (SW),
        .MAX_SAMPLES  (stpd_pkg::DEFAULT_MAX_SAMPLES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (smp_if),
        .results    (res_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .reports    (reports)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // result-side backpressure: stall runs of random length between ready runs
    initial
    begin
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if (stalls_on)
                begin
                    hold_left = $urandom_range(1, 6);
                    run_left  = $urandom_range(0, 12);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("[smooth_threshold_peak_detector_core] ERROR");
        $finish;
    end

    function automatic int clamp_level(input int v);
        if (v > LEVEL_MAX)
            return LEVEL_MAX;
        if (v < LEVEL_MIN)
            return LEVEL_MIN;
        return v;
    endfunction

    function automatic logic signed [SW-1:0] pick_level();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel <= 4)
            v = (aim_high ? cur_high : cur_low) + int'($urandom_range(0, 3000)) - 1500;
        else if (sel <= 6)
            v = int'($urandom_range(0, 65535)) + LEVEL_MIN;
        else if (sel == 7)
            v = $urandom_range(0, 1) ? LEVEL_MAX : LEVEL_MIN;
        else
            v = int'($urandom_range(0, 8000)) - 4000;
        v = clamp_level(v);
        return v[SW-1:0];
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] level, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        smp_if.valid   <= 1'b1;
        smp_if.sample  <= level;
        smp_if.is_last <= last;
        @(posedge clk);
        while (!smp_if.ready)
            @(posedge clk);
        burst_left--;
        sent_count++;
        if (last)
            stream_total++;
    endtask

    task automatic send_stream(input int length);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                aim_high = !aim_high;
            send_sample(pick_level(), i == length - 1);
        end
    endtask

    // let every predicted result drain, then let the result queue settle
    task automatic await_idle();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_levels(input int high, input int low, input bit spare_write);
        cfg_we    <= 1'b1;
        cfg_index <= stpd_pkg::CFG_HIGH_THRESHOLD;
        cfg_data  <= SW'(high);
        @(posedge clk);
        cfg_index <= stpd_pkg::CFG_LOW_THRESHOLD;
        cfg_data  <= SW'(low);
        @(posedge clk);
        if (spare_write)
        begin
            cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
            cfg_data  <= SW'($urandom_range(0, 65535));
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        cur_high = high;
        cur_low  = low;
    endtask

    task automatic program_random_levels();
        int mode;
        int high;
        int low;
        mode = $urandom_range(0, 3);
        case (mode)
            0:
            begin
                high = stpd_pkg::HIGH_THRESHOLD_RESET;
                low  = stpd_pkg::LOW_THRESHOLD_RESET;
            end
            1:
            begin
                high = int'($urandom_range(0, 16000)) - 8000;
                low  = clamp_level(high - int'($urandom_range(0, 3000)));
            end
            2:
            begin
                high = int'($urandom_range(0, 65535)) + LEVEL_MIN;
                low  = int'($urandom_range(0, 65535)) + LEVEL_MIN;
            end
            default:
            begin
                // crossed: re-arm level at or above the report level
                high = int'($urandom_range(0, 16000)) - 8000;
                low  = clamp_level(high + int'($urandom_range(0, 2000)));
            end
        endcase
        program_levels(high, low, $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        int random_target;
        int length;
        int pick;
        rst_n          = 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= stpd_pkg::CFG_HIGH_THRESHOLD;
        cfg_data       <= '0;
        smp_if.valid   <= 1'b0;
        smp_if.sample  <= '0;
        smp_if.is_last <= 1'b0;
        sent_count   = 0;
        stream_total = 0;
        burst_left   = 0;
        cur_high     = stpd_pkg::HIGH_THRESHOLD_RESET;
        cur_low      = stpd_pkg::LOW_THRESHOLD_RESET;
        aim_high     = 1'b0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: single-sample streams pass through, then a stream that
        // reports, disarms, re-arms and reports again, closing on the extremes
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd3000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        send_sample(16'sd21845, 1'b0);
        send_sample(-16'sd21846, 1'b1);
        await_idle();

        // top report level, bottom re-arm level: nothing can report
        program_levels(LEVEL_MAX, LEVEL_MIN, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b1);
        await_idle();

        // crossed extremes: anything above the bottom reports, and anything below the top re-arms at once
        program_levels(LEVEL_MIN, LEVEL_MAX, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd5, 1'b1);
        await_idle();

        random_target = sent_count + RANDOM_ITEMS;
        while (sent_count < random_target)
        begin
            program_random_levels();
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5))
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    length = 1;
                else if (pick <= 6)
                    length = $urandom_range(2, 12);
                else if (pick <= 8)
                    length = $urandom_range(13, 30);
                else
                    length = $urandom_range(31, 80);
                send_stream(length);
            end
            await_idle();
        end

        $display("Sent %0d samples in %0d streams over several threshold settings;",
                 sent_count, stream_total);
        $display("checked %0d results, %0d of them threshold reports.", checked, reports);
        if (fail_count == 0)
            $display("[smooth_threshold_peak_detector_core] OK");
        else
            $display("[smooth_threshold_peak_detector_core] ERROR");
        $finish;
    end

endmodule
